// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication with reset disable.
`define CHK_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Plain clocked property without reset disable.
`define CHK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== hdl/fsts_pkg.sv =====
// Package for the five-state task scheduler: state codes, action codes and the task state type.
// No dependencies.
`default_nettype none
package fsts_pkg;
   localparam logic [2:0] ST_NOTCREATED = 3'd0;
   localparam logic [2:0] ST_NEW        = 3'd1;
   localparam logic [2:0] ST_READY      = 3'd2;
   localparam logic [2:0] ST_RUN        = 3'd3;
   localparam logic [2:0] ST_BLOCKED    = 3'd4;
   localparam logic [2:0] ST_EXIT       = 3'd5;
   localparam logic [2:0] ST_FINISHED   = 3'd6;
   localparam logic       ACT_LOAD      = 1'b0;
   localparam logic       ACT_TICK      = 1'b1;
   typedef logic [2:0] task_state_type;
endpackage
`default_nettype wire

// ===== hdl/five_state_task_scheduler_fcfs.sv =====
// Five-state FCFS task scheduler. A load request (req_tuser low) writes one byte of the
// burst table (slot 0 start tick, then CPU and I/O bursts alternating). A tick request
// (req_tuser high) walks the tasks in index order. Each task takes these steps: three
// table reads through the single read port, the capture of the last read data, the exit
// check with the decrement write-back, the transition and the step to the next task.
// The very first tick skips the exit check and sends no report. A normal tick runs from
// acceptance through the task walk, a wrap-up step and one report per task before the
// next request can be taken. A tick that finds every task at exit or finished only
// reports. Reports wait while rsp_tready is held low.
// The burst table lives in a synchronous RAM of NUM_TASKS*NUM_SLOTS bytes; per-task
// state, positions and both queues are small register files.
// Depends on fsts_pkg, fsts_table_mem.
`default_nettype none
module five_state_task_scheduler_fcfs
   import fsts_pkg::*;
#(
   parameter int NUM_TASKS = 4,
   parameter int NUM_SLOTS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // task_req[1:0], slot[4:2], value[12:5]
   input  wire logic        req_tuser,  // action: load or tick
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,  // task_index[1:0], task_state[4:2], all_done[5]
   output logic             rsp_tlast   // last report of this tick
);
   localparam int TW  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int SW  = $clog2(NUM_SLOTS);
   localparam int PW  = $clog2(NUM_SLOTS + 2);
   localparam int AW  = $clog2(NUM_TASKS * NUM_SLOTS);
   localparam int CW  = $clog2(NUM_TASKS + 1);

   // states of the sequencer
   localparam logic [3:0] S_IDLE = 4'd0, S_RD0 = 4'd1, S_RD1 = 4'd2, S_RD2 = 4'd3,
      S_WAIT = 4'd4, S_EXEC = 4'd5, S_TRAN = 4'd6, S_NEXT = 4'd7, S_OUT = 4'd8,
      S_DONE = 4'd9;

   logic [3:0]  st_ff, st_in;
   logic [TW-1:0] t_ff, t_in;
   logic        first_ff, first_in;      // this tick is the transition-only tick
   logic        skip_ff, skip_in;        // nothing active: report only
   logic [15:0] tick_ff, tick_in;
   task_state_type states_ff [NUM_TASKS];
   task_state_type states_in [NUM_TASKS];
   logic [PW-1:0] pos_ff [NUM_TASKS];
   logic [PW-1:0] pos_in [NUM_TASKS];
   task_state_type shown_ff [NUM_TASKS];
   task_state_type shown_in [NUM_TASKS];
   logic        run_v_ff, run_v_in;
   logic [TW-1:0] run_ff, run_in;
   logic [TW-1:0] rq_ff [NUM_TASKS];
   logic [TW-1:0] rq_in [NUM_TASKS];
   logic [CW-1:0] rcnt_ff, rcnt_in;
   logic [TW-1:0] bq_ff [NUM_TASKS];
   logic [TW-1:0] bq_in [NUM_TASKS];
   logic [CW-1:0] bcnt_ff, bcnt_in;
   logic [7:0]  start_ff, start_in, cur_ff, cur_in, nxt_ff, nxt_in;
   logic        done_ff, done_in;
   logic [TW-1:0] o_ff, o_in;

   // memory port
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_data;

   fsts_table_mem #(.DEPTH(NUM_TASKS * NUM_SLOTS), .AW(AW)) u_mem (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   logic       in_act;
   logic [1:0] in_task;
   logic [2:0] in_slot;
   logic [7:0] in_val;
   assign in_act  = req_tuser;
   assign in_task = req_tdata[1:0];
   assign in_slot = req_tdata[4:2];
   assign in_val  = req_tdata[12:5];

   assign req_tready = (st_ff == S_IDLE);
   assign rsp_tvalid = (st_ff == S_OUT);
   assign rsp_tdata  = {2'b00, done_ff, shown_ff[o_ff], 2'(o_ff)};
   assign rsp_tlast  = (o_ff == TW'(NUM_TASKS - 1));

   function automatic logic [AW-1:0] addr_of(input logic [TW-1:0] t, input logic [SW-1:0] s);
      return AW'(t) * AW'(NUM_SLOTS) + AW'(s);
   endfunction

   logic [PW-1:0] p_cur;
   logic          p_ok, p1_ok;
   assign p_cur = pos_ff[t_ff];
   assign p_ok  = (p_cur < PW'(NUM_SLOTS));
   assign p1_ok = (p_cur + PW'(1) < PW'(NUM_SLOTS));

   always_comb begin
      logic any_act;
      logic [7:0] cur;
      logic [TW-1:0] rh, bh;
      logic rne, bne;
      int w;
      task_state_type s;
      logic [PW-1:0] pp;
      st_in = st_ff; t_in = t_ff; first_in = first_ff; skip_in = skip_ff;
      tick_in = tick_ff; states_in = states_ff; pos_in = pos_ff; shown_in = shown_ff;
      run_v_in = run_v_ff; run_in = run_ff; rq_in = rq_ff; rcnt_in = rcnt_ff;
      bq_in = bq_ff; bcnt_in = bcnt_ff; start_in = start_ff; cur_in = cur_ff;
      nxt_in = nxt_ff; done_in = done_ff; o_in = o_ff;
      wr_en = 1'b0; wr_addr = '0; wr_data = in_val; rd_addr = '0;
      any_act = 1'b0;
      for (int k = 0; k < NUM_TASKS; k++) if (states_ff[k] < ST_EXIT) any_act = 1'b1;
      cur = cur_ff; rh = rq_ff[0]; bh = bq_ff[0];
      rne = (rcnt_ff != '0); bne = (bcnt_ff != '0); w = 0; s = states_ff[t_ff];
      pp = p_cur;
      unique case (st_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (in_act == ACT_LOAD) begin
                  if (32'(in_task) < NUM_TASKS && 32'(in_slot) < NUM_SLOTS) begin
                     wr_en = 1'b1;
                     wr_addr = addr_of(TW'(in_task), SW'(in_slot));
                  end
               end else begin
                  t_in = '0;
                  first_in = (tick_ff == 16'd0);
                  skip_in = !any_act && (tick_ff != 16'd0);
                  for (int k = 0; k < NUM_TASKS; k++) shown_in[k] = states_ff[k];
                  st_in = skip_in ? S_DONE : S_RD0;
               end
            end
         end
         S_RD0: begin
            rd_addr = addr_of(t_ff, '0);
            st_in = S_RD1;
         end
         S_RD1: begin
            start_in = rd_data;
            rd_addr = addr_of(t_ff, SW'(p_cur));
            st_in = S_RD2;
         end
         S_RD2: begin
            cur_in = p_ok ? rd_data : 8'd0;
            rd_addr = addr_of(t_ff, SW'(p_cur + PW'(1)));
            st_in = S_WAIT;
         end
         S_WAIT: begin
            nxt_in = p1_ok ? rd_data : 8'd0;
            st_in = first_ff ? S_TRAN : S_EXEC;
         end
         S_EXEC: begin
            // exit check, then countdown with write-back
            if (cur_ff == 8'd0 && nxt_ff == 8'd0) begin
               if (s != ST_EXIT && s != ST_FINISHED) begin
                  s = ST_EXIT;
                  w = 0;
                  for (int k = 0; k < NUM_TASKS; k++)
                     if (k < int'(bcnt_ff) && bq_ff[k] != t_ff) begin
                        bq_in[TW'(w)] = bq_ff[k]; w++;
                     end
                  bcnt_in = CW'(w);
                  w = 0;
                  for (int k = 0; k < NUM_TASKS; k++)
                     if (k < int'(rcnt_ff) && rq_ff[k] != t_ff) begin
                        rq_in[TW'(w)] = rq_ff[k]; w++;
                     end
                  rcnt_in = CW'(w);
                  if (run_v_ff && run_ff == t_ff) run_v_in = 1'b0;
               end else s = ST_FINISHED;
            end
            states_in[t_ff] = s;
            shown_in[t_ff] = s;
            if ((s == ST_RUN || (s == ST_BLOCKED && bcnt_in != '0 && bq_in[0] == t_ff))
                && p_ok && cur_ff != 8'd0) begin
               cur_in = cur_ff - 8'd1;
               wr_en = 1'b1;
               wr_addr = addr_of(t_ff, SW'(p_cur));
               wr_data = cur_in;
            end
            st_in = S_TRAN;
         end
         S_TRAN: begin
            rh = rq_ff[0]; bh = bq_ff[0]; rne = (rcnt_ff != '0); bne = (bcnt_ff != '0);
            if (pp < PW'(NUM_SLOTS)) pp = pp + PW'(1);
            case (s)
               ST_NOTCREATED:
                  if (16'(start_ff) <= tick_ff) states_in[t_ff] = ST_NEW;
               ST_NEW: begin
                  if (!run_v_ff && !rne) begin
                     states_in[t_ff] = ST_RUN; run_v_in = 1'b1; run_in = t_ff;
                  end else begin
                     states_in[t_ff] = ST_READY;
                     if (rcnt_ff < CW'(NUM_TASKS)) begin
                        rq_in[rcnt_ff[TW-1:0]] = t_ff; rcnt_in = rcnt_ff + CW'(1);
                     end
                  end
               end
               ST_READY:
                  if (rne && rh == t_ff && !run_v_ff) begin
                     for (int k = 0; k < NUM_TASKS - 1; k++) rq_in[k] = rq_ff[k + 1];
                     rcnt_in = rcnt_ff - CW'(1);
                     states_in[t_ff] = ST_RUN; run_v_in = 1'b1; run_in = t_ff;
                  end
               ST_RUN:
                  if (run_v_ff && run_ff == t_ff && cur_ff == 8'd0) begin
                     states_in[t_ff] = ST_BLOCKED; pos_in[t_ff] = pp; run_v_in = 1'b0;
                     if (bcnt_ff < CW'(NUM_TASKS)) begin
                        bq_in[bcnt_ff[TW-1:0]] = t_ff; bcnt_in = bcnt_ff + CW'(1);
                     end
                  end
               ST_BLOCKED:
                  if (cur_ff == 8'd0 && bne && bh == t_ff) begin
                     for (int k = 0; k < NUM_TASKS - 1; k++) bq_in[k] = bq_ff[k + 1];
                     bcnt_in = bcnt_ff - CW'(1);
                     if (rcnt_ff < CW'(NUM_TASKS)) begin
                        rq_in[rcnt_ff[TW-1:0]] = t_ff; rcnt_in = rcnt_ff + CW'(1);
                     end
                     states_in[t_ff] = ST_READY; pos_in[t_ff] = pp;
                  end
               ST_EXIT: states_in[t_ff] = ST_FINISHED;
               default: ;
            endcase
            st_in = S_NEXT;
         end
         S_NEXT: begin
            if (t_ff == TW'(NUM_TASKS - 1)) st_in = S_DONE;
            else begin
               t_in = t_ff + TW'(1); st_in = S_RD0;
            end
         end
         S_DONE: begin
            if (tick_ff != 16'hFFFF) tick_in = tick_ff + 16'd1;
            done_in = !any_act;
            o_in = '0;
            st_in = first_ff ? S_IDLE : S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) begin
               if (o_ff == TW'(NUM_TASKS - 1)) st_in = S_IDLE;
               else o_in = o_ff + TW'(1);
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; t_ff <= '0; first_ff <= 1'b0; skip_ff <= 1'b0;
         tick_ff <= '0; run_v_ff <= 1'b0; run_ff <= '0; rcnt_ff <= '0; bcnt_ff <= '0;
         done_ff <= 1'b0; o_ff <= '0;
         for (int k = 0; k < NUM_TASKS; k++) begin
            states_ff[k] <= ST_NOTCREATED; pos_ff[k] <= PW'(1);
         end
      end else begin
         st_ff <= st_in; t_ff <= t_in; first_ff <= first_in; skip_ff <= skip_in;
         tick_ff <= tick_in; run_v_ff <= run_v_in; run_ff <= run_in;
         rcnt_ff <= rcnt_in; bcnt_ff <= bcnt_in; done_ff <= done_in; o_ff <= o_in;
         states_ff <= states_in; pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      rq_ff <= rq_in; bq_ff <= bq_in; shown_ff <= shown_in;
      start_ff <= start_in; cur_ff <= cur_in; nxt_ff <= nxt_in;
   end
endmodule
`default_nettype wire

// ===== hdl/fsts_table_mem.sv =====
// Burst table memory: one write port, one read port, registered read data.
// Depends on nothing.
`default_nettype none
module fsts_table_mem #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic [7:0]         rd_data
);
   logic [7:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hdl/fsts_checker.sv =====
// Port-level checker for the scheduler, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module fsts_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast
);
   `CHK_IMPL(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled report changed")
   `CHK_IMPL(a_no_overlap, clock, reset, rsp_tvalid |-> !req_tready, "request taken while reporting")
   `CHK_IMPL(a_state_range, clock, reset, rsp_tvalid |-> rsp_tdata[4:2] != 3'd7, "bad state code")
   `CHK_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_tvalid, "report right after reset")
endmodule
bind five_state_task_scheduler_fcfs fsts_checker u_chk (.*);
`default_nettype wire
